### rtl/ccsp_pkg.sv
// Shared types, constants and hash helper for the checker cell state painter.
`default_nettype none
package ccsp_pkg;

  localparam int TILE_W   = 16;
  localparam int TICK_W   = 32;
  localparam int PIX_W    = 32;
  localparam int COLOR_W  = 24;
  localparam int RATE_W   = 17;
  localparam int SEED_W   = 32;
  localparam int HASH_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W   = TICK_W + RATE_W;
  localparam int PHASE_LSB = 16;

  localparam int PIPE_DEPTH = 8;
  localparam int DIV_STEPS  = TILE_W / PIPE_DEPTH;

  localparam logic [HASH_W-1:0] HASH_MULT = 32'h61C88647;

  localparam logic [TILE_W-1:0]  COLUMNS_RST = 16'd1;
  localparam logic [RATE_W-1:0]  RATE_RST    = 17'h10000;
  localparam logic [COLOR_W-1:0] FILL_RST    = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS   = 3'd0,
    REG_PATTERN   = 3'd1,
    REG_DYNAMICS  = 3'd2,
    REG_RATE      = 3'd3,
    REG_SEED      = 3'd4,
    REG_MODES     = 3'd5,
    REG_FILL      = 3'd6,
    REG_CLEAR     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DYN_PASS   = 2'd0,
    DYN_INVERT = 2'd1,
    DYN_TOGGLE = 2'd2,
    DYN_MASK   = 2'd3
  } dyn_mode_t;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_SOLID    = 2'd1,
    ACT_TEXTURED = 2'd2
  } paint_act_t;

  localparam logic [1:0] FILL_SAMPLED  = 2'd1;
  localparam logic [1:0] FILL_TEXTURED = 2'd2;
  localparam logic [1:0] CLR_OFF       = 2'd0;
  localparam logic [1:0] CLR_SAMPLED   = 2'd2;
  localparam logic [1:0] CLR_TEXTURED  = 2'd3;

  typedef struct packed {
    logic rand_bit;
    logic mask_bit;
    logic phase_bit;
  } hash_bits_t;

  typedef struct packed {
    logic quo_lsb;
    logic rem_lsb;
  } div_bits_t;

  // one xorshift-multiply round of the tile hash
  function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] x;
    x = v ^ (v >> 16);
    return x * HASH_MULT;
  endfunction

endpackage
`default_nettype wire

### rtl/ccsp_div_pipe.sv
// Pipelined restoring divider giving the low bits of tile / columns and tile % columns.
`default_nettype none
module ccsp_div_pipe (
  input  logic                       clk,
  input  logic [ccsp_pkg::TILE_W-1:0] tile,
  input  logic [ccsp_pkg::TILE_W-1:0] divisor,
  output ccsp_pkg::div_bits_t         res
);
  import ccsp_pkg::*;

  logic [TILE_W-1:0] rem_q    [1:PIPE_DEPTH];
  logic [TILE_W-1:0] dvd_q    [1:PIPE_DEPTH];
  logic              qb_q     [1:PIPE_DEPTH];
  logic [TILE_W-1:0] rem_in   [0:PIPE_DEPTH-1];
  logic [TILE_W-1:0] dvd_in   [0:PIPE_DEPTH-1];
  logic [TILE_W-1:0] rem_next [0:PIPE_DEPTH-1];
  logic [TILE_W-1:0] dvd_next [0:PIPE_DEPTH-1];
  logic              qb_next  [0:PIPE_DEPTH-1];

  assign rem_in[0] = '0;
  assign dvd_in[0] = tile;

  for (genvar s = 1; s < PIPE_DEPTH; s++) begin : g_link
    assign rem_in[s] = rem_q[s];
    assign dvd_in[s] = dvd_q[s];
  end

  always_comb begin
    logic [TILE_W:0]   t;
    logic [TILE_W-1:0] r;
    logic [TILE_W-1:0] d;
    logic              qb;
    for (int s = 0; s < PIPE_DEPTH; s++) begin
      r  = rem_in[s];
      d  = dvd_in[s];
      qb = 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {r, d[TILE_W-1]};
        d = {d[TILE_W-2:0], 1'b0};
        if (t >= {1'b0, divisor}) begin
          t  = t - {1'b0, divisor};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        r = t[TILE_W-1:0];
      end
      rem_next[s] = r;
      dvd_next[s] = d;
      qb_next[s]  = qb;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s <= PIPE_DEPTH; s++) begin
      rem_q[s] <= rem_next[s-1];
      dvd_q[s] <= dvd_next[s-1];
      qb_q[s]  <= qb_next[s-1];
    end
  end

  assign res.quo_lsb = qb_q[PIPE_DEPTH];
  assign res.rem_lsb = rem_q[PIPE_DEPTH][0];

endmodule
`default_nettype wire

### rtl/ccsp_hash_pipe.sv
// Pipelined phase product and tile hashes, one multiplier per stage and path.
`default_nettype none
module ccsp_hash_pipe (
  input  logic                        clk,
  input  logic [ccsp_pkg::TILE_W-1:0] tile,
  input  logic [ccsp_pkg::TICK_W-1:0] tick,
  input  logic [ccsp_pkg::SEED_W-1:0] seed,
  input  logic [ccsp_pkg::RATE_W-1:0] rate,
  output ccsp_pkg::hash_bits_t        res
);
  import ccsp_pkg::*;

  logic [HASH_W-1:0] key1;
  logic [PROD_W-1:0] prod1;
  logic [HASH_W-1:0] base2;
  logic [HASH_W-1:0] phase2;
  logic [HASH_W-1:0] a3, a4, a5;
  logic [HASH_W-1:0] sum3, b4, b5, b6;
  logic              ph3, ph4, ph5, ph6, ph7, ph8;
  logic              abit6, abit7, abit8;
  logic              bbit7, bbit8;

  always_ff @(posedge clk) begin
    key1   <= seed + {{(SEED_W-TILE_W){1'b0}}, tile};
    prod1  <= {{RATE_W{1'b0}}, tick} * {{TICK_W{1'b0}}, rate};

    base2  <= key1 * HASH_MULT;
    phase2 <= prod1[PHASE_LSB +: HASH_W];

    a3     <= mix_round(base2);
    sum3   <= base2 + phase2;
    ph3    <= phase2[0];

    a4     <= mix_round(a3);
    b4     <= mix_round(sum3);
    ph4    <= ph3;

    a5     <= mix_round(a4);
    b5     <= mix_round(b4);
    ph5    <= ph4;

    abit6  <= a5[0] ^ a5[16];
    b6     <= mix_round(b5);
    ph6    <= ph5;

    abit7  <= abit6;
    bbit7  <= b6[0] ^ b6[16];
    ph7    <= ph6;

    abit8  <= abit7;
    bbit8  <= bbit7;
    ph8    <= ph7;
  end

  assign res.rand_bit  = abit8;
  assign res.mask_bit  = bbit8;
  assign res.phase_bit = ph8;

endmodule
`default_nettype wire

### rtl/checker_cell_state_painter.sv
// Top level of the checker cell state painter: config registers, pipeline and paint decision.
//
//   channel   handshake                 payload
//   command   start, busy               tile_number, tick, region_cleared, center_pixel
//   result    done (one-cycle strobe)   cell_on, paint_action, paint_color
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One transaction enters per cycle while busy is low.
// Each result passes through the 8-stage divider (2 quotient bits per stage) and the
// matching hash chain of four 32x32 multiplies, plus one output register.
// busy is high only during reset; synchronous reset drops every transaction in flight.
// Results are never held back, so the pipeline never stalls.
`default_nettype none
module checker_cell_state_painter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ccsp_pkg::TILE_W-1:0]       tile_number,
  input  logic [ccsp_pkg::TICK_W-1:0]       tick,
  input  logic                              region_cleared,
  input  logic [ccsp_pkg::PIX_W-1:0]        center_pixel,
  output logic                              done,
  output logic                              cell_on,
  output logic [1:0]                        paint_action,
  output logic [ccsp_pkg::PIX_W-1:0]        paint_color,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ccsp_pkg::*;

  logic [TILE_W-1:0]  columns;
  logic               pattern_select;
  logic [1:0]         dynamics_mode;
  logic [RATE_W-1:0]  rate_q16;
  logic [SEED_W-1:0]  hash_seed;
  logic [3:0]         paint_modes;
  logic [COLOR_W-1:0] on_rgb;
  logic [COLOR_W-1:0] off_rgb;

  logic [TILE_W-1:0]  cols_eff;
  logic               accept;
  logic               vld     [1:PIPE_DEPTH];
  logic               cleared [1:PIPE_DEPTH];
  logic [PIX_W-1:0]   pix     [1:PIPE_DEPTH];

  div_bits_t          div_res;
  hash_bits_t         hash_res;

  logic               pat_bit;
  logic               on_next;
  logic [1:0]         act_next;
  logic [PIX_W-1:0]   color_next;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign cols_eff  = (columns == '0) ? COLUMNS_RST : columns;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns        <= COLUMNS_RST;
      pattern_select <= 1'b0;
      dynamics_mode  <= DYN_PASS;
      rate_q16       <= RATE_RST;
      hash_seed      <= '0;
      paint_modes    <= '0;
      on_rgb         <= FILL_RST;
      off_rgb        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_COLUMNS:  columns        <= cfg_data[TILE_W-1:0];
        REG_PATTERN:  pattern_select <= cfg_data[0];
        REG_DYNAMICS: dynamics_mode  <= cfg_data[1:0];
        REG_RATE:     rate_q16       <= cfg_data[RATE_W-1:0];
        REG_SEED:     hash_seed      <= cfg_data[SEED_W-1:0];
        REG_MODES:    paint_modes    <= cfg_data[3:0];
        REG_FILL:     on_rgb         <= cfg_data[COLOR_W-1:0];
        REG_CLEAR:    off_rgb        <= cfg_data[COLOR_W-1:0];
        default:      ;
      endcase
    end
  end

  ccsp_div_pipe u_div (
    .clk     (clk),
    .tile    (tile_number),
    .divisor (cols_eff),
    .res     (div_res)
  );

  ccsp_hash_pipe u_hash (
    .clk  (clk),
    .tile (tile_number),
    .tick (tick),
    .seed (hash_seed),
    .rate (rate_q16),
    .res  (hash_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= PIPE_DEPTH; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[1] <= accept;
      for (int s = 2; s <= PIPE_DEPTH; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cleared[1] <= region_cleared;
    pix[1]     <= center_pixel;
    for (int s = 2; s <= PIPE_DEPTH; s++) begin
      cleared[s] <= cleared[s-1];
      pix[s]     <= pix[s-1];
    end
  end

  always_comb begin
    pat_bit = pattern_select ? hash_res.rand_bit : (div_res.quo_lsb ^ div_res.rem_lsb);
    case (dynamics_mode)
      DYN_PASS:   on_next = pat_bit;
      DYN_INVERT: on_next = !pat_bit;
      DYN_TOGGLE: on_next = pat_bit ^ hash_res.phase_bit;
      DYN_MASK:   on_next = pat_bit & hash_res.mask_bit;
      default:    on_next = pat_bit;
    endcase

    if (on_next) begin
      act_next   = ACT_SOLID;
      color_next = {{(PIX_W-COLOR_W){1'b0}}, on_rgb};
      if (paint_modes[1:0] == FILL_SAMPLED && cleared[PIPE_DEPTH]) begin
        color_next = pix[PIPE_DEPTH];
      end else if (paint_modes[1:0] == FILL_TEXTURED) begin
        act_next = ACT_TEXTURED;
      end
    end else begin
      act_next   = ACT_SOLID;
      color_next = {{(PIX_W-COLOR_W){1'b0}}, off_rgb};
      if (paint_modes[3:2] == CLR_OFF) begin
        act_next   = ACT_CLEAR;
        color_next = '0;
      end else if (paint_modes[3:2] == CLR_SAMPLED && cleared[PIPE_DEPTH]) begin
        color_next = pix[PIPE_DEPTH];
      end else if (paint_modes[3:2] == CLR_TEXTURED) begin
        act_next = ACT_TEXTURED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[PIPE_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    cell_on      <= on_next;
    paint_action <= act_next;
    paint_color  <= color_next;
  end

endmodule
`default_nettype wire

### rtl/ccsp_checker.sv
// Port-level assertions for the checker cell state painter, bound to the top level.
`default_nettype none
module ccsp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            cell_on,
  input logic [1:0]                      paint_action,
  input logic [ccsp_pkg::PIX_W-1:0]      paint_color
);
  import ccsp_pkg::*;

  localparam int LATENCY = PIPE_DEPTH + 1;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted transaction");

  a_no_done_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_action_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (paint_action == ACT_CLEAR || paint_action == ACT_SOLID ||
              paint_action == ACT_TEXTURED))
    else $error("illegal paint action");

  a_clear_is_off_black: assert property (@(posedge clk) disable iff (rst)
    (done && paint_action == ACT_CLEAR) |-> (!cell_on && paint_color == '0))
    else $error("clear action on an on tile or with nonzero color");

endmodule

bind checker_cell_state_painter ccsp_checker u_ccsp_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for the checker cell state painter: queued driver, monitor and paint predictor.
`timescale 1ns / 1ps
module tb;
  import ccsp_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam logic [1:0]  FILL_PLAIN     = 2'd0;
  localparam logic [1:0]  FILL_RANDOM    = 2'd3;
  localparam logic [1:0]  CLR_COLOR      = 2'd1;

  typedef struct {
    logic [TILE_W-1:0] tile;
    logic [TICK_W-1:0] tick;
    logic              cleared;
    logic [PIX_W-1:0]  pixel;
  } tile_req_t;

  typedef struct {
    logic             on;
    paint_act_t       action;
    logic [PIX_W-1:0] color;
  } paint_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [TILE_W-1:0] tile_number = '0;
  logic [TICK_W-1:0] tick = '0;
  logic region_cleared = 1'b0;
  logic [PIX_W-1:0] center_pixel = '0;
  logic done;
  logic cell_on;
  logic [1:0] paint_action;
  logic [PIX_W-1:0] paint_color;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the configuration registers
  logic [TILE_W-1:0]  sh_columns = COLUMNS_RST;
  logic               sh_pattern = 1'b0;
  dyn_mode_t          sh_dyn     = DYN_PASS;
  logic [RATE_W-1:0]  sh_rate    = RATE_RST;
  logic [SEED_W-1:0]  sh_seed    = '0;
  logic [3:0]         sh_modes   = '0;
  logic [COLOR_W-1:0] sh_fill    = FILL_RST;
  logic [COLOR_W-1:0] sh_clear   = '0;

  tile_req_t  tile_q[$];
  paint_res_t paint_exp_q[$];
  tile_req_t  cur_req;
  int         n_issued = 0;
  int         n_accepted = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 30;

  always #2 clk = ~clk;

  checker_cell_state_painter i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .tile_number    (tile_number),
    .tick           (tick),
    .region_cleared (region_cleared),
    .center_pixel   (center_pixel),
    .done           (done),
    .cell_on        (cell_on),
    .paint_action   (paint_action),
    .paint_color    (paint_color),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  function automatic logic [HASH_W-1:0] tile_hash(input logic [HASH_W-1:0] v);
    logic [HASH_W-1:0] x;
    x = v;
    for (int i = 0; i < 3; i++) begin
      x = (x ^ (x >> 16)) * HASH_MULT;
    end
    return x ^ (x >> 16);
  endfunction

  function automatic paint_res_t predict_paint(input tile_req_t r);
    logic [TILE_W-1:0] cols;
    logic [TILE_W-1:0] row;
    logic [TILE_W-1:0] col;
    logic [HASH_W-1:0] base;
    logic [HASH_W-1:0] h;
    logic [63:0]       prod;
    logic [31:0]       phase;
    logic              st;
    logic [1:0]        mode;
    paint_res_t        res;
    cols = (sh_columns == '0) ? 16'd1 : sh_columns;
    row = r.tile / cols;
    col = r.tile % cols;
    base = (sh_seed + {16'd0, r.tile}) * HASH_MULT;
    prod = {32'd0, r.tick} * {47'd0, sh_rate};
    phase = prod[47:16];
    if (sh_pattern) begin
      h = tile_hash(base);
      st = h[0];
    end else begin
      st = row[0] ^ col[0];
    end
    case (sh_dyn)
      DYN_INVERT: st = ~st;
      DYN_TOGGLE: st = st ^ phase[0];
      DYN_MASK: begin
        h = tile_hash(base + phase);
        st = st & h[0];
      end
      default: ;
    endcase
    res.on = st;
    res.action = ACT_SOLID;
    if (st) begin
      mode = sh_modes[1:0];
      res.color = {8'd0, sh_fill};
      if (mode == FILL_SAMPLED && r.cleared) res.color = r.pixel;
      else if (mode == FILL_TEXTURED) res.action = ACT_TEXTURED;
    end else begin
      mode = sh_modes[3:2];
      res.color = {8'd0, sh_clear};
      if (mode == CLR_OFF) begin
        res.action = ACT_CLEAR;
        res.color = '0;
      end else if (mode == CLR_SAMPLED && r.cleared) begin
        res.color = r.pixel;
      end else if (mode == CLR_TEXTURED) begin
        res.action = ACT_TEXTURED;
      end
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    tile_req_t nxt;
    if (start && !busy) begin
      paint_exp_q.push_back(predict_paint(cur_req));
      n_accepted++;
    end
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (tile_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = tile_q.pop_front();
        cur_req = nxt;
        start <= 1'b1;
        tile_number <= nxt.tile;
        tick <= nxt.tick;
        region_cleared <= nxt.cleared;
        center_pixel <= nxt.pixel;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic       active;
    paint_res_t exp_res;
    active = 1'b0;
    if (cfg_valid && cfg_ready) begin
      active = 1'b1;
      case (cfg_reg_t'(cfg_index))
        REG_COLUMNS:  sh_columns = cfg_data[TILE_W-1:0];
        REG_PATTERN:  sh_pattern = cfg_data[0];
        REG_DYNAMICS: sh_dyn     = dyn_mode_t'(cfg_data[1:0]);
        REG_RATE:     sh_rate    = cfg_data[RATE_W-1:0];
        REG_SEED:     sh_seed    = cfg_data[SEED_W-1:0];
        REG_MODES:    sh_modes   = cfg_data[3:0];
        REG_FILL:     sh_fill    = cfg_data[COLOR_W-1:0];
        REG_CLEAR:    sh_clear   = cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
    if (start && !busy) active = 1'b1;
    if (!rst && done) begin
      active = 1'b1;
      if (paint_exp_q.size() == 0) begin
        $display("%0t unexpected result: cell_on %b action %0d color %h",
                 $time, cell_on, paint_action, paint_color);
        errors++;
      end else begin
        exp_res = paint_exp_q.pop_front();
        if (cell_on !== exp_res.on) begin
          $display("%0t cell_on mismatch: expected %b actual %b", $time, exp_res.on, cell_on);
          errors++;
        end
        if (paint_action !== exp_res.action) begin
          $display("%0t paint_action mismatch: expected %0d actual %0d",
                   $time, exp_res.action, paint_action);
          errors++;
        end
        if (paint_color !== exp_res.color) begin
          $display("%0t paint_color mismatch: expected %h actual %h",
                   $time, exp_res.color, paint_color);
          errors++;
        end
      end
    end
    idle_cycles = active ? 0 : idle_cycles + 1;
  end

  task automatic add_tile(input logic [TILE_W-1:0] t, input logic [TICK_W-1:0] tk,
                          input logic c, input logic [PIX_W-1:0] px);
    tile_req_t r;
    r.tile = t;
    r.tick = tk;
    r.cleared = c;
    r.pixel = px;
    tile_q.push_back(r);
    n_issued++;
  endtask

  task automatic wait_drain();
    while (n_accepted != n_issued || paint_exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [15:0] cols, input logic pat, input dyn_mode_t dyn,
                              input logic [16:0] rate, input logic [31:0] seed,
                              input logic [1:0] clr_mode, input logic [1:0] fill_mode,
                              input logic [23:0] fill, input logic [23:0] clr);
    write_reg(REG_COLUMNS, {16'd0, cols});
    write_reg(REG_PATTERN, {31'd0, pat});
    write_reg(REG_DYNAMICS, {30'd0, dyn});
    write_reg(REG_RATE, {15'd0, rate});
    write_reg(REG_SEED, seed);
    write_reg(REG_MODES, {28'd0, clr_mode, fill_mode});
    write_reg(REG_FILL, {8'd0, fill});
    write_reg(REG_CLEAR, {8'd0, clr});
  endtask

  function automatic logic [23:0] rand_color();
    case ($urandom_range(3))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] cols;
    logic [16:0] rate;
    logic [15:0] t;
    logic [31:0] tk;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset configuration
    add_tile(16'h0000, 32'h00000000, 1'b0, 32'h00000000);
    add_tile(16'h0001, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
    add_tile(16'hFFFF, 32'h00000001, 1'b1, 32'h12345678);
    add_tile(16'h0002, 32'h80000000, 1'b0, 32'hFFFFFFFF);

    // zero columns, invert, rate above one, both sampled modes
    wait_drain();
    program_regs(16'd0, 1'b0, DYN_INVERT, 17'h1FFFF, 32'hFFFFFFFF,
                 CLR_SAMPLED, FILL_SAMPLED, 24'h000000, 24'hFFFFFF);
    add_tile(16'h0003, 32'hFFFFFFFF, 1'b1, 32'hDEADBEEF);
    add_tile(16'h0004, 32'h00000007, 1'b0, 32'hA5A5A5A5);
    add_tile(16'hFFFF, 32'h00000000, 1'b1, 32'h00000000);
    add_tile(16'h0000, 32'h0000FFFF, 1'b0, 32'hFFFFFFFF);
    add_tile(16'h0006, 32'h12345678, 1'b1, 32'h5A5A5A5A);

    // hashed pattern, toggle by phase, both textured modes
    wait_drain();
    program_regs(16'hFFFF, 1'b1, DYN_TOGGLE, 17'h10000, 32'h00000000,
                 CLR_TEXTURED, FILL_TEXTURED, 24'h123456, 24'hFFFFFF);
    add_tile(16'h0000, 32'h00000000, 1'b1, 32'h11111111);
    add_tile(16'h0001, 32'h00000001, 1'b0, 32'h22222222);
    add_tile(16'hFFFE, 32'hFFFFFFFE, 1'b1, 32'h33333333);
    add_tile(16'hFFFF, 32'hFFFFFFFF, 1'b0, 32'h44444444);
    add_tile(16'h1234, 32'h00000003, 1'b1, 32'h55555555);

    // phase masked, fill mode three, clear to color
    wait_drain();
    program_regs(16'd7, 1'b0, DYN_MASK, 17'h00000, 32'h5A5A5A5A,
                 CLR_COLOR, FILL_RANDOM, 24'hFFFFFF, 24'h0F0F0F);
    for (int i = 0; i < 6; i++) add_tile(16'(i * 3 + 1), 32'hFFFFFFFF, 1'b1, 32'hCAFEF00D);

    // pass through, color fill, clear to zero
    wait_drain();
    program_regs(16'd3, 1'b1, DYN_PASS, 17'h08000, 32'h9E3779B9,
                 CLR_OFF, FILL_PLAIN, 24'hABCDEF, 24'h555555);
    for (int i = 0; i < 4; i++) add_tile(16'(i), 32'(i * 5), i[0], 32'hFEEDFACE);

    // random phases
    for (int p = 0; p < 12; p++) begin
      wait_drain();
      send_idle_pct = (p < 4) ? 30 : (p < 8) ? 86 : 0;
      case ($urandom_range(4))
        0: cols = 16'd0;
        1: cols = 16'd1;
        2: cols = 16'hFFFF;
        3: cols = 16'($urandom_range(64, 2));
        default: cols = 16'($urandom);
      endcase
      case ($urandom_range(4))
        0: rate = 17'h00000;
        1: rate = 17'h10000;
        2: rate = 17'h1FFFF;
        3: rate = 17'($urandom_range(65535));
        default: rate = 17'($urandom);
      endcase
      program_regs(cols, 1'($urandom), dyn_mode_t'($urandom_range(3)), rate, $urandom,
                   2'($urandom), 2'($urandom), rand_color(), rand_color());
      for (int i = 0; i < 48; i++) begin
        t = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
        case ($urandom_range(7))
          0: tk = 32'h00000000;
          1: tk = 32'hFFFFFFFF;
          2: tk = $urandom_range(1023);
          default: tk = $urandom;
        endcase
        add_tile(t, tk, 1'($urandom), $urandom);
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && paint_exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t watchdog expired with %0d results pending", $time, paint_exp_q.size());
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
rtl/ccsp_pkg.sv
rtl/ccsp_div_pipe.sv
rtl/ccsp_hash_pipe.sv
rtl/checker_cell_state_painter.sv
rtl/ccsp_checker.sv
sim/tb.sv
